### hw/rtl/alist_pkg.sv
// Shared types, constants and command/status bundles for the array list core.
package alist_pkg;

  // List capacity and derived widths
  localparam int DEPTH  = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_DISPLAY = 3'd1,
    OP_INSERT  = 3'd2,
    OP_REPLACE = 3'd3,
    OP_DELETE  = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_BAD_POS   = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_t;

  // Input transaction
  typedef struct packed {
    logic [2:0]               operation;
    logic [6:0]               position;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] new_value;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic signed [DATA_W-1:0] element;
    logic [2:0]               status;
    logic [6:0]               entry_count;
    logic                     last;
  } rsp_t;

  // Controller state
  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DISP_RD,
    S_DISP_OUT,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_REP_RD,
    S_REP_CMP,
    S_DEL_RD,
    S_DEL_CMP,
    S_DEL_SRD,
    S_DEL_SWR
  } state_t;

  // Walk index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  // RAM read address source
  typedef enum logic [1:0] {
    RA_IDX,
    RA_IDX_DEC,
    RA_IDX_INC
  } ra_sel_t;

  // RAM write address source
  typedef enum logic {
    WA_COUNT,
    WA_IDX
  } wa_sel_t;

  // RAM write data source
  typedef enum logic [1:0] {
    WD_VALUE,
    WD_NEW_VALUE,
    WD_RDATA
  } wd_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    ra_sel_t ra_sel;
    logic    wr_en;
    wa_sel_t wa_sel;
    wd_sel_t wd_sel;
    logic    hit_clr;
    logic    hit_set;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    emit;
    status_t emit_status;
    logic    emit_elem;
    logic    emit_last;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       count_zero;
    logic       full;
    logic       pos_bad;
    logic       idx_at_pos;
    logic       idx_last;
    logic       match;
    logic       hit;
  } dp_stat_t;

endpackage

### hw/rtl/array_list_insert_delete_replace_core.sv
// Top level of the ordered array list core: controller plus datapath.
//
// An ordered list of up to DEPTH (32) signed 32-bit entries held in a
// single-write, single-read RAM with registered read data. A transaction is
// taken when start is high and busy is low; busy stays high until the last
// result has been issued. Each result sits on the result port for one cycle
// with done high and cannot be held off by the receiver. Every operation
// passes through a decode state, and each entry visited goes through a state
// that issues the RAM read and then one that uses the data. No clearing
// pass is needed after reset: only entries below the count are ever used.
module array_list_insert_delete_replace_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  alist_pkg::cmd_t   cmd,
  output logic              done,
  output alist_pkg::rsp_t   result
);
  import alist_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  alist_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  alist_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

### hw/rtl/alist_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/alist_dp.sv
// Datapath: entry store, count, walk index, match logic and result register.
module alist_dp (
  input  logic               clk,
  input  logic               rst,
  input  alist_pkg::cmd_t    cmd,
  input  alist_pkg::ctrl_cmd_t ctrl,
  output alist_pkg::dp_stat_t  stat,
  output logic               done,
  output alist_pkg::rsp_t    result
);
  import alist_pkg::*;

  cmd_t             cmd_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic             hit;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [DATA_W-1:0] rdata;
  logic [CNT_W:0]   count_p1;
  logic [CNT_W:0]   idx_p1;

  // Latched transaction fields
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_q <= cmd;
    end
  end

  // Entry count
  always_comb begin
    count_next = count;
    if (ctrl.cnt_inc) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.cnt_dec) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Walk index
  always_comb begin
    unique case (ctrl.idx_op)
      IDX_HOLD:  idx_next = idx;
      IDX_ZERO:  idx_next = '0;
      IDX_COUNT: idx_next = count;
      IDX_INC:   idx_next = idx + CNT_W'(1);
      IDX_DEC:   idx_next = idx - CNT_W'(1);
      default:   idx_next = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

  // Replace hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.hit_clr) begin
      hit <= 1'b0;
    end else if (ctrl.hit_set) begin
      hit <= 1'b1;
    end
  end

  // RAM address and data selection
  always_comb begin
    unique case (ctrl.ra_sel)
      RA_IDX:     raddr = idx[ADDR_W-1:0];
      RA_IDX_DEC: raddr = idx[ADDR_W-1:0] - ADDR_W'(1);
      RA_IDX_INC: raddr = idx[ADDR_W-1:0] + ADDR_W'(1);
      default:    raddr = idx[ADDR_W-1:0];
    endcase
    unique case (ctrl.wa_sel)
      WA_COUNT: waddr = count[ADDR_W-1:0];
      WA_IDX:   waddr = idx[ADDR_W-1:0];
      default:  waddr = idx[ADDR_W-1:0];
    endcase
    unique case (ctrl.wd_sel)
      WD_VALUE:     wdata = cmd_q.value;
      WD_NEW_VALUE: wdata = cmd_q.new_value;
      WD_RDATA:     wdata = rdata;
      default:      wdata = rdata;
    endcase
  end

  alist_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Status towards the controller
  assign count_p1 = {1'b0, count} + (CNT_W+1)'(1);
  assign idx_p1   = {1'b0, idx} + (CNT_W+1)'(1);

  always_comb begin
    stat.op         = cmd_q.operation;
    stat.count_zero = (count == '0);
    stat.full       = ({1'b0, count} >= (CNT_W+1)'(DEPTH));
    stat.pos_bad    = (cmd_q.position == 7'd0) ||
                      (8'(cmd_q.position) > 8'(count_p1));
    stat.idx_at_pos = (8'(idx_p1) == 8'(cmd_q.position));
    // Current index is the top entry
    stat.idx_last   = (idx_p1 == {1'b0, count});
    stat.match      = (rdata == cmd_q.value);
    stat.hit        = hit;
  end

  // Result register, one cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      result.element     <= ctrl.emit_elem ? rdata : '0;
      result.status      <= ctrl.emit_status;
      result.entry_count <= 7'(count_next);
      result.last        <= ctrl.emit_last;
    end
  end

endmodule

### hw/rtl/alist_ctrl.sv
// Controller: sequences each operation over the datapath and entry store.
module alist_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  alist_pkg::dp_stat_t  stat,
  output alist_pkg::ctrl_cmd_t ctrl,
  output logic                 busy
);
  import alist_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_IDLE;
        unique case (op_t'(stat.op))
          OP_DISPLAY: if (!stat.count_zero) state_next = S_DISP_RD;
          OP_INSERT:  if (!stat.full && !stat.pos_bad) state_next = S_INS_RD;
          OP_REPLACE: if (!stat.count_zero) state_next = S_REP_RD;
          OP_DELETE:  if (!stat.count_zero) state_next = S_DEL_RD;
          default:    state_next = S_IDLE;
        endcase
      end
      S_DISP_RD:  state_next = S_DISP_OUT;
      S_DISP_OUT: state_next = stat.idx_last ? S_IDLE : S_DISP_RD;
      S_INS_RD:   state_next = stat.idx_at_pos ? S_INS_PUT : S_INS_WR;
      S_INS_WR:   state_next = S_INS_RD;
      S_INS_PUT:  state_next = S_IDLE;
      S_REP_RD:   state_next = S_REP_CMP;
      S_REP_CMP:  state_next = stat.idx_last ? S_IDLE : S_REP_RD;
      S_DEL_RD:   state_next = S_DEL_CMP;
      S_DEL_CMP: begin
        if (stat.match) begin
          state_next = S_DEL_SRD;
        end else if (stat.idx_last) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_DEL_SRD:  state_next = stat.idx_last ? S_IDLE : S_DEL_SWR;
      S_DEL_SWR:  state_next = S_DEL_SRD;
      default:    state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ctrl             = '0;
    ctrl.idx_op      = IDX_HOLD;
    ctrl.ra_sel      = RA_IDX;
    ctrl.wa_sel      = WA_IDX;
    ctrl.wd_sel      = WD_RDATA;
    ctrl.emit_status = STAT_OK;
    ctrl.emit_last   = 1'b1;
    busy             = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        ctrl.load = start;
      end
      S_DECODE: begin
        unique case (op_t'(stat.op))
          OP_APPEND: begin
            ctrl.emit = 1'b1;
            if (stat.full) begin
              ctrl.emit_status = STAT_FULL;
            end else begin
              ctrl.wr_en   = 1'b1;
              ctrl.wa_sel  = WA_COUNT;
              ctrl.wd_sel  = WD_VALUE;
              ctrl.cnt_inc = 1'b1;
            end
          end
          OP_DISPLAY: begin
            if (stat.count_zero) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = STAT_EMPTY;
            end else begin
              ctrl.idx_op = IDX_ZERO;
            end
          end
          OP_INSERT: begin
            if (stat.full) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = STAT_FULL;
            end else if (stat.pos_bad) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = STAT_BAD_POS;
            end else begin
              ctrl.idx_op = IDX_COUNT;
            end
          end
          OP_REPLACE: begin
            if (stat.count_zero) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = STAT_EMPTY;
            end else begin
              ctrl.idx_op  = IDX_ZERO;
              ctrl.hit_clr = 1'b1;
            end
          end
          OP_DELETE: begin
            if (stat.count_zero) begin
              ctrl.emit        = 1'b1;
              ctrl.emit_status = STAT_EMPTY;
            end else begin
              ctrl.idx_op = IDX_ZERO;
            end
          end
          default: begin
            // Unused operation codes give a plain ok result
            ctrl.emit = 1'b1;
          end
        endcase
      end
      S_DISP_RD: begin
        ctrl.ra_sel = RA_IDX;
      end
      S_DISP_OUT: begin
        ctrl.emit      = 1'b1;
        ctrl.emit_elem = 1'b1;
        ctrl.emit_last = stat.idx_last;
        ctrl.idx_op    = IDX_INC;
      end
      S_INS_RD: begin
        ctrl.ra_sel = RA_IDX_DEC;
      end
      S_INS_WR: begin
        // Move the entry below up into the current slot
        ctrl.wr_en  = 1'b1;
        ctrl.wa_sel = WA_IDX;
        ctrl.wd_sel = WD_RDATA;
        ctrl.idx_op = IDX_DEC;
      end
      S_INS_PUT: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wa_sel  = WA_IDX;
        ctrl.wd_sel  = WD_VALUE;
        ctrl.cnt_inc = 1'b1;
        ctrl.emit    = 1'b1;
      end
      S_REP_RD: begin
        ctrl.ra_sel = RA_IDX;
      end
      S_REP_CMP: begin
        ctrl.idx_op = IDX_INC;
        if (stat.match) begin
          ctrl.wr_en   = 1'b1;
          ctrl.wa_sel  = WA_IDX;
          ctrl.wd_sel  = WD_NEW_VALUE;
          ctrl.hit_set = 1'b1;
        end
        if (stat.idx_last) begin
          ctrl.emit        = 1'b1;
          ctrl.emit_status = (stat.hit || stat.match) ? STAT_OK : STAT_NOT_FOUND;
        end
      end
      S_DEL_RD: begin
        ctrl.ra_sel = RA_IDX;
      end
      S_DEL_CMP: begin
        if (!stat.match) begin
          if (stat.idx_last) begin
            ctrl.emit        = 1'b1;
            ctrl.emit_status = STAT_NOT_FOUND;
          end else begin
            ctrl.idx_op = IDX_INC;
          end
        end
      end
      S_DEL_SRD: begin
        if (stat.idx_last) begin
          ctrl.cnt_dec = 1'b1;
          ctrl.emit    = 1'b1;
        end else begin
          ctrl.ra_sel = RA_IDX_INC;
        end
      end
      S_DEL_SWR: begin
        // Move the entry above down into the current slot
        ctrl.wr_en  = 1'b1;
        ctrl.wa_sel = WA_IDX;
        ctrl.wd_sel = WD_RDATA;
        ctrl.idx_op = IDX_INC;
      end
      default: begin
        ctrl.emit = 1'b0;
      end
    endcase
  end

endmodule

### tb/alist_result_checker.sv
`timescale 1ns / 1ps
// Checker for the array list core: tracks the list, predicts every result and compares.
module alist_result_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  alist_pkg::cmd_t cmd,
  input  logic            done,
  input  alist_pkg::rsp_t result,
  output int              fail_count,
  output int              outstanding,
  output int              results_checked,
  output int              list_len,
  output int              peak_len
);
  import alist_pkg::*;

  localparam int REPORT_MAX = 10;

  // Shadow copy of the list; only entries below shadow_len are ever read
  logic signed [DATA_W-1:0] shadow [DEPTH];
  int                       shadow_len = 0;
  int                       n_fail     = 0;
  int                       n_checked  = 0;
  int                       n_peak     = 0;
  rsp_t                     expected_rsp [$];

  // Queue one expected result, tagged with the list length after the operation
  function automatic void add_expected(logic signed [DATA_W-1:0] elem, status_t st,
                                       logic fin);
    rsp_t r;
    r.element     = elem;
    r.status      = st;
    r.entry_count = 7'(shadow_len);
    r.last        = fin;
    expected_rsp.push_back(r);
  endfunction

  function automatic void log_failure(string msg);
    n_fail++;
    if (n_fail <= REPORT_MAX) $display("%0t ns: %s", $time, msg);
  endfunction

  // Apply one accepted transaction to the shadow list and queue its results
  task automatic apply_list_op(input cmd_t c);
    int at;
    bit hit;
    int pos;
    pos = int'(c.position);
    case (c.operation)
      OP_APPEND: begin
        if (shadow_len >= DEPTH) begin
          add_expected('0, STAT_FULL, 1'b1);
        end else begin
          shadow[shadow_len] = c.value;
          shadow_len++;
          add_expected('0, STAT_OK, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (shadow_len == 0) begin
          add_expected('0, STAT_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < shadow_len; i++)
            add_expected(shadow[i], STAT_OK, i == shadow_len - 1);
        end
      end
      OP_INSERT: begin
        // full takes precedence over a bad position
        if (shadow_len >= DEPTH) begin
          add_expected('0, STAT_FULL, 1'b1);
        end else if (pos < 1 || pos > shadow_len + 1) begin
          add_expected('0, STAT_BAD_POS, 1'b1);
        end else begin
          for (int i = shadow_len; i > pos - 1; i--) shadow[i] = shadow[i - 1];
          shadow[pos - 1] = c.value;
          shadow_len++;
          add_expected('0, STAT_OK, 1'b1);
        end
      end
      OP_REPLACE: begin
        if (shadow_len == 0) begin
          add_expected('0, STAT_EMPTY, 1'b1);
        end else begin
          hit = 1'b0;
          for (int i = 0; i < shadow_len; i++) begin
            if (shadow[i] == c.value) begin
              shadow[i] = c.new_value;
              hit       = 1'b1;
            end
          end
          add_expected('0, hit ? STAT_OK : STAT_NOT_FOUND, 1'b1);
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          add_expected('0, STAT_EMPTY, 1'b1);
        end else begin
          // first match only
          at = -1;
          for (int i = 0; i < shadow_len; i++)
            if (at < 0 && shadow[i] == c.value) at = i;
          if (at < 0) begin
            add_expected('0, STAT_NOT_FOUND, 1'b1);
          end else begin
            for (int i = at; i + 1 < shadow_len; i++) shadow[i] = shadow[i + 1];
            shadow_len--;
            add_expected('0, STAT_OK, 1'b1);
          end
        end
      end
      default: begin
        // spare operation codes: one plain ok result, list untouched
        add_expected('0, STAT_OK, 1'b1);
      end
    endcase
    if (shadow_len > n_peak) n_peak = shadow_len;
  endtask

  // Results are compared before a new transaction is predicted at the same edge
  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      shadow_len = 0;
      expected_rsp.delete();
    end else begin
      if (done) begin
        n_checked++;
        if (expected_rsp.size() == 0) begin
          log_failure($sformatf("unexpected result: element=%0d status=%0d count=%0d last=%0b",
                                result.element, result.status, result.entry_count,
                                result.last));
        end else begin
          want = expected_rsp.pop_front();
          if (result.element !== want.element || result.status !== want.status ||
              result.entry_count !== want.entry_count || result.last !== want.last)
            log_failure($sformatf({"result %0d mismatch: expected element=%0d status=%0d ",
                                   "count=%0d last=%0b, got element=%0d status=%0d ",
                                   "count=%0d last=%0b"},
                                  n_checked, want.element, want.status, want.entry_count,
                                  want.last, result.element, result.status,
                                  result.entry_count, result.last));
        end
      end
      if (start && !busy) apply_list_op(cmd);
    end
    fail_count      <= n_fail;
    outstanding     <= expected_rsp.size();
    results_checked <= n_checked;
    list_len        <= shadow_len;
    peak_len        <= n_peak;
  end

endmodule

### tb/tb_array_list_insert_delete_replace_core.sv
`timescale 1ns / 1ps
// Testbench top for the array list core: clock, reset, command stimulus, timeout and verdict.
module tb_array_list_insert_delete_replace_core;
  import alist_pkg::*;

  // Operation codes the core does not define
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  localparam int RAND_ITEMS  = 360;
  localparam int PHASE_LEN   = 50;
  localparam int IDLE_PCT    = 37;
  localparam int POOL_MAX    = 64;
  localparam int TAIL_CYCLES = 20;
  localparam int CYCLE_LIMIT = 400000;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  cmd_t cmd   = '0;
  logic busy;
  logic done;
  rsp_t result;

  int fail_count;
  int outstanding;
  int results_checked;
  int list_len;
  int peak_len;
  int cycles = 0;
  bit idle_on = 1'b1;

  // Values sent with appends and inserts, so that matches are likely
  logic signed [DATA_W-1:0] value_pool [$];
  int n_append = 0, n_display = 0, n_insert = 0, n_replace = 0, n_delete = 0, n_spare = 0;

  always #2 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  array_list_insert_delete_replace_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  alist_result_checker chk (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .done            (done),
    .result          (result),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .list_len        (list_len),
    .peak_len        (peak_len)
  );

  // Watchdog
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still awaited", cycles, outstanding);
    $display("TEST FAILED");
    $finish;
  end

  function automatic cmd_t make_cmd(logic [2:0] op, logic [6:0] pos,
                                    logic signed [DATA_W-1:0] v,
                                    logic signed [DATA_W-1:0] nv);
    cmd_t c;
    c.operation = op;
    c.position  = pos;
    c.value     = v;
    c.new_value = nv;
    return c;
  endfunction

  // Small values collide often, extremes and full-range values cover every bit
  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
      4:          return $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      default:    return $urandom();
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_pooled();
    if (value_pool.size() == 0 || $urandom_range(0, 3) == 0) return rand_value();
    return value_pool[$urandom_range(0, value_pool.size() - 1)];
  endfunction

  // Mostly legal insert positions, sometimes any 7-bit value
  function automatic logic [6:0] rand_pos();
    if ($urandom_range(0, 4) == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, list_len + 1));
  endfunction

  // Present one transaction and wait for it to be taken; start is left high
  task automatic send(input cmd_t c);
    if (idle_on) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (c.operation)
      OP_APPEND:  n_append++;
      OP_DISPLAY: n_display++;
      OP_INSERT:  n_insert++;
      OP_REPLACE: n_replace++;
      OP_DELETE:  n_delete++;
      default:    n_spare++;
    endcase
    if (c.operation == OP_APPEND || c.operation == OP_INSERT) begin
      value_pool.push_back(c.value);
      if (value_pool.size() > POOL_MAX) void'(value_pool.pop_front());
    end
  endtask

  // Hold off until every expected result has arrived and the core is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, bad positions, extremes, duplicate matches, spare codes
    send(make_cmd(OP_DISPLAY, 7'd0, 32'sd0, 32'sd0));
    send(make_cmd(OP_REPLACE, 7'd0, 32'sd5, 32'sd6));
    send(make_cmd(OP_DELETE, 7'd0, 32'sd5, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd0, 32'sd1, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd2, 32'sd1, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd1, VAL_MIN, 32'sd0));
    send(make_cmd(OP_APPEND, 7'd0, VAL_MAX, 32'sd0));
    send(make_cmd(OP_APPEND, 7'd0, -32'sd1, 32'sd0));
    send(make_cmd(OP_APPEND, 7'd0, 32'sd0, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd127, 32'sd3, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd5, 32'sh5555_5555, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd7, 32'sd4, 32'sd0));
    send(make_cmd(OP_INSERT, 7'd2, 32'shAAAA_AAAA, 32'sd0));
    send(make_cmd(OP_REPLACE, 7'd0, -32'sd1, VAL_MAX));
    send(make_cmd(OP_REPLACE, 7'd0, 32'sd0, VAL_MIN));
    send(make_cmd(OP_REPLACE, 7'd0, 32'sd12345, 32'sd1));
    send(make_cmd(OP_DELETE, 7'd0, VAL_MAX, 32'sd0));
    send(make_cmd(OP_DELETE, 7'd0, 32'sd999, 32'sd0));
    send(make_cmd(OP_DISPLAY, 7'd0, 32'sd0, 32'sd0));
    for (int k = int'(OP_SPARE_FIRST); k <= int'(OP_SPARE_LAST); k++)
      send(make_cmd(3'(k), 7'($urandom), $urandom(), $urandom()));
    send(make_cmd(OP_DELETE, 7'd0, VAL_MIN, 32'sd0));
    drain();

    // Fill to capacity, then hit the full list with appends and inserts
    for (int k = 0; k < DEPTH + 2; k++)
      send(make_cmd(OP_APPEND, 7'($urandom), rand_value(), $urandom()));
    send(make_cmd(OP_INSERT, 7'd1, rand_value(), 32'sd0));
    send(make_cmd(OP_INSERT, 7'd0, rand_value(), 32'sd0));
    send(make_cmd(OP_DISPLAY, 7'($urandom), $urandom(), $urandom()));
    send(make_cmd(OP_DELETE, 7'($urandom), rand_pooled(), $urandom()));

    // Random: alternating growth and shrink phases so the list swings full and empty
    for (int n = 0; n < RAND_ITEMS; n++) begin : rand_item
      int r;
      bit grow;
      int th_app, th_ins, th_disp, th_rep;
      grow    = ((n / PHASE_LEN) % 2) == 0;
      th_app  = grow ? 35 : 15;
      th_ins  = grow ? 65 : 30;
      th_disp = grow ? 75 : 40;
      th_rep  = grow ? 85 : 55;
      idle_on = !(n >= 150 && n < 250);
      if (n % 90 == 45) drain();
      r = $urandom_range(0, 99);
      if (r < th_app)
        send(make_cmd(OP_APPEND, 7'($urandom), rand_value(), $urandom()));
      else if (r < th_ins)
        send(make_cmd(OP_INSERT, rand_pos(), rand_value(), $urandom()));
      else if (r < th_disp)
        send(make_cmd(OP_DISPLAY, 7'($urandom), $urandom(), $urandom()));
      else if (r < th_rep)
        send(make_cmd(OP_REPLACE, 7'($urandom), rand_pooled(), rand_value()));
      else if (r < 97)
        send(make_cmd(OP_DELETE, 7'($urandom), rand_pooled(), $urandom()));
      else
        send(make_cmd(3'($urandom_range(int'(OP_SPARE_FIRST), int'(OP_SPARE_LAST))),
                      7'($urandom), $urandom(), $urandom()));
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d appends, %0d displays, %0d inserts, %0d replaces, %0d deletes, %0d spare codes",
             n_append, n_display, n_insert, n_replace, n_delete, n_spare);
    $display("Summary: %0d results compared, list length peaked at %0d of %0d, %0d mismatches",
             results_checked, peak_len, DEPTH, fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/alist_pkg.sv
hw/rtl/alist_ram.sv
hw/rtl/alist_dp.sv
hw/rtl/alist_ctrl.sv
hw/rtl/array_list_insert_delete_replace_core.sv
tb/alist_result_checker.sv
tb/tb_array_list_insert_delete_replace_core.sv
